// ----- rtl/smcn_pkg.sv -----
// package for the sorted multiset count / nearest block
// holds default sizes, opcode codes and count limits; no dependencies
package smcn_pkg;

    localparam int DEF_CAPACITY   = 128;
    localparam int DEF_VALUE_BITS = 16;

    // match count port width and its saturation point
    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

endpackage

// ----- rtl/sorted_multiset_count_nearest.sv -----
// top level: sorted table of values with insert and count / nearest query
// uses smcn_pkg and one smcn_ram instance for the entry storage
//
//  channel   ports                                       handshake
//  --------  ------------------------------------------  ---------------------------
//  request   i_opcode, i_value                           i_start high, o_busy low
//  result    o_table_full, o_found, o_match_count,       o_valid high for one cycle
//            o_lower_valid, o_nearest_lower,
//            o_higher_valid, o_nearest_higher
//
// one request at a time; o_busy is high from the cycle after acceptance up to
// the cycle before the result strobe, which follows in the next cycle. work per
// request:
//   insert into a full table: refused, table untouched
//   insert: one ram read and one compare-and-move per entry greater than the
//     value, each shifted up; the value is written at the head when every
//     stored entry is greater or the table is empty
//   query: one ram read per stored entry through the shared
//     comparator; nothing to read on an empty table
// reset (synchronous, active low) empties the table; entry storage needs no
// clearing since only entries below the occupancy are ever read.
// the receiver cannot stall: each result is shown for exactly one cycle and a
// new request may be accepted in that same cycle.
module sorted_multiset_count_nearest #(
    parameter int CAPACITY   = smcn_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = smcn_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_opcode,
    input  logic [VALUE_BITS-1:0]        i_value,
    output logic                         o_valid,
    output logic                         o_table_full,
    output logic                         o_found,
    output logic [smcn_pkg::COUNT_W-1:0] o_match_count,
    output logic                         o_lower_valid,
    output logic [VALUE_BITS-1:0]        o_nearest_lower,
    output logic                         o_higher_valid,
    output logic [VALUE_BITS-1:0]        o_nearest_higher
);

    import smcn_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_IRD  = 2'd1;   // insert: fetch entry below the hole
    localparam logic [1:0] S_ICMP = 2'd2;   // insert: compare, move up or drop value in
    localparam logic [1:0] S_QRY  = 2'd3;   // query: stream entries through comparator

    logic [1:0]            r_state, n_state;
    logic [OCC_W-1:0]      r_occ, n_occ;
    logic [OCC_W-1:0]      r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [VALUE_BITS-1:0] r_value, n_value;

    // query accumulators
    logic [COUNT_W-1:0]    r_cnt, n_cnt;
    logic                  r_lv, n_lv;
    logic                  r_hv, n_hv;
    logic [VALUE_BITS-1:0] r_lo, n_lo;
    logic [VALUE_BITS-1:0] r_hi, n_hi;

    // result registers
    logic                  r_valid, n_valid;
    logic                  r_full, n_full;
    logic                  r_found, n_found;
    logic [COUNT_W-1:0]    r_mcnt, n_mcnt;
    logic                  r_olv, n_olv;
    logic [VALUE_BITS-1:0] r_olo, n_olo;
    logic                  r_ohv, n_ohv;
    logic [VALUE_BITS-1:0] r_ohi, n_ohi;

    // ram side
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    // shared comparator: stored entry against the request value
    logic cmp_eq;
    logic cmp_lt;
    logic [OCC_W-1:0] idx_m1;

    assign cmp_eq = (ram_rdata == r_value);
    assign cmp_lt = (ram_rdata < r_value);
    assign idx_m1 = r_idx - 1'b1;

    smcn_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_value   = r_value;
        n_cnt     = r_cnt;
        n_lv      = r_lv;
        n_hv      = r_hv;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_valid   = 1'b0;
        n_full    = r_full;
        n_found   = r_found;
        n_mcnt    = r_mcnt;
        n_olv     = r_olv;
        n_olo     = r_olo;
        n_ohv     = r_ohv;
        n_ohi     = r_ohi;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = r_value;
        ram_raddr = idx_m1[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value = i_value;
                    n_cnt   = '0;
                    n_lv    = 1'b0;
                    n_hv    = 1'b0;
                    if (i_opcode == OP_INSERT) begin
                        // hole starts just past the last entry
                        n_idx   = r_occ;
                        n_state = S_IRD;
                    end else begin
                        n_idx   = '0;
                        n_state = S_QRY;
                    end
                end
            end

            S_IRD: begin
                if (r_occ == OCC_W'(CAPACITY)) begin
                    // refused, table untouched
                    n_valid = 1'b1;
                    n_full  = 1'b1;
                    n_found = 1'b0;
                    n_mcnt  = '0;
                    n_olv   = 1'b0;
                    n_olo   = '0;
                    n_ohv   = 1'b0;
                    n_ohi   = '0;
                    n_state = S_IDLE;
                end else if (r_idx == '0) begin
                    // hole reached the head
                    ram_we  = 1'b1;
                    n_occ   = r_occ + 1'b1;
                    n_valid = 1'b1;
                    n_full  = 1'b0;
                    n_found = 1'b0;
                    n_mcnt  = '0;
                    n_olv   = 1'b0;
                    n_olo   = '0;
                    n_ohv   = 1'b0;
                    n_ohi   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ICMP;
                end
            end

            S_ICMP: begin
                ram_we = 1'b1;
                if (!cmp_eq && !cmp_lt) begin
                    // entry greater than value: move it up into the hole
                    ram_wdata = ram_rdata;
                    n_idx     = idx_m1;
                    n_state   = S_IRD;
                end else begin
                    // equal or smaller entry stays, value lands after it
                    n_occ   = r_occ + 1'b1;
                    n_valid = 1'b1;
                    n_full  = 1'b0;
                    n_found = 1'b0;
                    n_mcnt  = '0;
                    n_olv   = 1'b0;
                    n_olo   = '0;
                    n_ohv   = 1'b0;
                    n_ohi   = '0;
                    n_state = S_IDLE;
                end
            end

            S_QRY: begin
                ram_raddr = r_idx[AW-1:0];
                if (r_idx != r_occ) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend) begin
                    if (cmp_eq) begin
                        if (r_cnt != COUNT_MAX) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (cmp_lt) begin
                        // ascending order: last smaller entry is the nearest
                        n_lv = 1'b1;
                        n_lo = ram_rdata;
                    end else if (!r_hv) begin
                        n_hv = 1'b1;
                        n_hi = ram_rdata;
                    end
                end
                if (r_idx == r_occ && !r_pend) begin
                    n_valid = 1'b1;
                    n_full  = 1'b0;
                    n_found = (r_cnt != '0);
                    n_mcnt  = r_cnt;
                    n_olv   = (r_cnt == '0) && r_lv;
                    n_olo   = ((r_cnt == '0) && r_lv) ? r_lo : '0;
                    n_ohv   = (r_cnt == '0) && r_hv;
                    n_ohi   = ((r_cnt == '0) && r_hv) ? r_hi : '0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_cnt   <= n_cnt;
        r_lv    <= n_lv;
        r_hv    <= n_hv;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_full  <= n_full;
        r_found <= n_found;
        r_mcnt  <= n_mcnt;
        r_olv   <= n_olv;
        r_olo   <= n_olo;
        r_ohv   <= n_ohv;
        r_ohi   <= n_ohi;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_table_full     = r_full;
    assign o_found          = r_found;
    assign o_match_count    = r_mcnt;
    assign o_lower_valid    = r_olv;
    assign o_nearest_lower  = r_olo;
    assign o_higher_valid   = r_ohv;
    assign o_nearest_higher = r_ohi;

    // accepted request always makes the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accepted request");

    // occupancy never passes the capacity
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    // a found query carries a count and no nearest values
    a_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_match_count != '0 && !o_lower_valid && !o_higher_valid))
        else $error("found result with inconsistent fields");

    // one strobe per request, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

endmodule

// ----- rtl/smcn_ram.sv -----
// generic single write / single read ram with registered read data
// standalone, no package needed
module smcn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for sorted_multiset_count_nearest: random and directed
// insert / query requests checked against a cycle-free table predictor
// depends on smcn_pkg and the sorted_multiset_count_nearest rtl
module testbench;

    import smcn_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam int VB  = DEF_VALUE_BITS;

    // cycles with no request taken and no result seen before the run is abandoned;
    // longest quiet stretch is an insert shifting a nearly full table or a long sender gap
    localparam int STALL_LIMIT = 4000;
    // quiet cycles after the last result, covers the longest insert shift
    localparam int TAIL_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              op;
        logic [VB-1:0]     value;
        bit                wait_drain;   // hold off until every answer is in
    } t_table_req;

    typedef struct packed {
        logic               table_full;
        logic               found;
        logic [COUNT_W-1:0] match_count;
        logic               lower_valid;
        logic [VB-1:0]      nearest_lower;
        logic               higher_valid;
        logic [VB-1:0]      nearest_higher;
    } t_table_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               i_opcode = OP_INSERT;
    logic [VB-1:0]      i_value = '0;
    logic               o_busy;
    logic               o_valid;
    logic               o_table_full;
    logic               o_found;
    logic [COUNT_W-1:0] o_match_count;
    logic               o_lower_valid;
    logic [VB-1:0]      o_nearest_lower;
    logic               o_higher_valid;
    logic [VB-1:0]      o_nearest_higher;

    sorted_multiset_count_nearest #(
        .CAPACITY   (CAP),
        .VALUE_BITS (VB)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_opcode         (i_opcode),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .o_table_full     (o_table_full),
        .o_found          (o_found),
        .o_match_count    (o_match_count),
        .o_lower_valid    (o_lower_valid),
        .o_nearest_lower  (o_nearest_lower),
        .o_higher_valid   (o_higher_valid),
        .o_nearest_higher (o_nearest_higher)
    );

    // requests still to be sent, answers still to come back
    t_table_req    request_q[$];
    t_table_answer answer_q[$];

    // predictor copy of the table: ascending, duplicates kept in arrival order
    logic [VB-1:0] shadow_entries[CAP];
    int            shadow_count = 0;

    // values the stimulus expects to be stored, used to aim queries and duplicates
    logic [VB-1:0] plan_vals[$];

    bit stim_ready = 1'b0;
    bit took_request = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    int idle_cycles = 0;
    int error_count = 0;
    int result_index = 0;

    // ------------------------------------------------------------------
    // predictor: applies one request to the shadow table, returns its answer
    // ------------------------------------------------------------------
    function automatic t_table_answer compute_answer(input logic op, input logic [VB-1:0] v);
        t_table_answer ans;
        int            pos;
        int            k;
        ans = '0;
        if (op == OP_INSERT) begin
            if (shadow_count >= CAP) begin
                // refused, table untouched
                ans.table_full = 1'b1;
            end else begin
                // new value goes after every entry not greater than it
                pos = 0;
                while (pos < shadow_count && shadow_entries[pos] <= v)
                    pos++;
                for (k = shadow_count; k > pos; k--)
                    shadow_entries[k] = shadow_entries[k-1];
                shadow_entries[pos] = v;
                shadow_count++;
            end
        end else begin
            for (k = 0; k < shadow_count; k++) begin
                if (shadow_entries[k] == v) begin
                    if (ans.match_count != COUNT_MAX)
                        ans.match_count = ans.match_count + 1'b1;
                end else if (shadow_entries[k] < v) begin
                    // ascending order, so the last one below wins
                    ans.lower_valid   = 1'b1;
                    ans.nearest_lower = shadow_entries[k];
                end else if (!ans.higher_valid) begin
                    ans.higher_valid   = 1'b1;
                    ans.nearest_higher = shadow_entries[k];
                end
            end
            // a hit suppresses the neighbor fields entirely
            if (ans.match_count != 0) begin
                ans.found          = 1'b1;
                ans.lower_valid    = 1'b0;
                ans.nearest_lower  = '0;
                ans.higher_valid   = 1'b0;
                ans.nearest_higher = '0;
            end
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_request(input logic op, input logic [VB-1:0] v,
                                          input bit drain);
        t_table_req req;
        req.op         = op;
        req.value      = v;
        req.wait_drain = drain;
        request_q.push_back(req);
        if (op == OP_INSERT && plan_vals.size() < CAP)
            plan_vals.push_back(v);
    endfunction

    // a stored value or one of its immediate neighbors (wraps at the ends); random while none is planned
    function automatic logic [VB-1:0] near_value();
        logic [VB-1:0] base;
        if (plan_vals.size() == 0)
            return VB'($urandom_range(0, (1 << VB) - 1));
        base = plan_vals[$urandom_range(0, plan_vals.size() - 1)];
        case ($urandom_range(0, 2))
            0:       return base - 1'b1;
            1:       return base + 1'b1;
            default: return base;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // stimulus plan, then end-of-run wait and verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [VB-1:0] hot_value;
        logic [VB-1:0] v;
        int            n;

        // directed part: empty table, extremes, neighbors, duplicates
        queue_request(OP_QUERY,  16'h0000, 1'b0);   // empty table, lowest key
        queue_request(OP_QUERY,  16'hFFFF, 1'b0);   // empty table, highest key
        queue_request(OP_INSERT, 16'h8000, 1'b0);
        queue_request(OP_QUERY,  16'h8000, 1'b0);   // single hit
        queue_request(OP_QUERY,  16'h7FFF, 1'b0);   // only a higher neighbor
        queue_request(OP_QUERY,  16'h8001, 1'b0);   // only a lower neighbor
        queue_request(OP_INSERT, 16'h0000, 1'b0);
        queue_request(OP_INSERT, 16'hFFFF, 1'b0);
        queue_request(OP_QUERY,  16'h0000, 1'b0);   // hit at the head
        queue_request(OP_QUERY,  16'hFFFF, 1'b0);   // hit at the tail
        queue_request(OP_QUERY,  16'h0001, 1'b0);
        queue_request(OP_QUERY,  16'hFFFE, 1'b0);
        queue_request(OP_INSERT, 16'h8000, 1'b0);   // duplicates land after the original
        queue_request(OP_INSERT, 16'h8000, 1'b0);
        queue_request(OP_QUERY,  16'h8000, 1'b0);
        queue_request(OP_INSERT, 16'h5555, 1'b0);
        queue_request(OP_INSERT, 16'hAAAA, 1'b0);
        queue_request(OP_QUERY,  16'h5556, 1'b0);
        queue_request(OP_QUERY,  16'hAAA9, 1'b0);
        queue_request(OP_INSERT, 16'h7FFF, 1'b0);   // lands just below the run of 8000s
        queue_request(OP_QUERY,  16'h7FFF, 1'b0);
        queue_request(OP_QUERY,  16'h8000, 1'b0);

        // fill phase: mixed inserts and queries while the table grows;
        // one hot value gets inserted many times to push the count up
        hot_value = VB'($urandom_range(0, (1 << VB) - 1));
        for (n = 0; n < 450; n++) begin
            if ($urandom_range(0, 99) < 35) begin
                case ($urandom_range(0, 3))
                    0:       v = hot_value;
                    1:       v = near_value();
                    2:       v = VB'($urandom_range(0, (1 << VB) - 1));
                    default: v = ($urandom_range(0, 1) != 0)
                                 ? {VB{1'b1}} - VB'($urandom_range(0, 1))
                                 : VB'($urandom_range(0, 1));
                endcase
                queue_request(OP_INSERT, v, n % 100 == 0);
            end else begin
                case ($urandom_range(0, 3))
                    0:       v = hot_value;
                    1, 2:    v = near_value();
                    default: v = VB'($urandom_range(0, (1 << VB) - 1));
                endcase
                queue_request(OP_QUERY, v, n % 100 == 0);
            end
        end

        // top the table up to capacity if the fill phase fell short
        while (plan_vals.size() < CAP)
            queue_request(OP_INSERT, near_value(), 1'b0);

        // full phase: mostly queries on a full table, some refused inserts
        for (n = 0; n < 330; n++) begin
            if ($urandom_range(0, 99) < 15)
                queue_request(OP_INSERT, VB'($urandom_range(0, (1 << VB) - 1)),
                              n % 110 == 0);
            else if ($urandom_range(0, 3) == 0)
                queue_request(OP_QUERY, VB'($urandom_range(0, (1 << VB) - 1)),
                              n % 110 == 0);
            else if ($urandom_range(0, 4) == 0)
                queue_request(OP_QUERY, hot_value, n % 110 == 0);
            else
                queue_request(OP_QUERY, near_value(), n % 110 == 0);
        end

        stim_ready = 1'b1;

        while (request_q.size() != 0 || answer_q.size() != 0)
            @(posedge i_clk);
        // let any stray strobe show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("sorted_multiset_count_nearest regression: pass");
        else
            $display("sorted_multiset_count_nearest regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: presents the head request at the falling edge; bursts of
    // requests separated by random gaps, some long enough to idle the block
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n || !stim_ready) begin
            i_start <= 1'b0;
        end else begin
            if (took_request) begin
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1, 2:    gap_left = $urandom_range(1, 6);
                        default: gap_left = $urandom_range(7, 160);
                    endcase
                end
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_start <= 1'b0;
            end else if (request_q.size() == 0 ||
                         (request_q[0].wait_drain && answer_q.size() != 0)) begin
                // nothing left, or a pause until the block has answered everything
                i_start <= 1'b0;
            end else begin
                i_start  <= 1'b1;
                i_opcode <= request_q[0].op;
                i_value  <= request_q[0].value;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks the result strobe against the oldest answer, then
    // records a newly taken request; also runs the stall watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_table_answer got;
        t_table_answer want;
        took_request = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                got.table_full     = o_table_full;
                got.found          = o_found;
                got.match_count    = o_match_count;
                got.lower_valid    = o_lower_valid;
                got.nearest_lower  = o_nearest_lower;
                got.higher_valid   = o_higher_valid;
                got.nearest_higher = o_nearest_higher;
                if (answer_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("result %0d: strobe with no request outstanding",
                                 result_index);
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display({"result %0d mismatch: expected full=%0b found=%0b",
                                      " cnt=%0d lo=%0b/%h hi=%0b/%h"},
                                     result_index, want.table_full, want.found,
                                     want.match_count,
                                     want.lower_valid, want.nearest_lower,
                                     want.higher_valid, want.nearest_higher);
                            $display({"                    actual   full=%0b found=%0b",
                                      " cnt=%0d lo=%0b/%h hi=%0b/%h"},
                                     got.table_full, got.found, got.match_count,
                                     got.lower_valid, got.nearest_lower,
                                     got.higher_valid, got.nearest_higher);
                        end
                    end
                end
                result_index++;
            end

            if (i_start && !o_busy) begin
                answer_q.push_back(compute_answer(i_opcode, i_value));
                if (request_q.size() != 0)
                    void'(request_q.pop_front());
                took_request = 1'b1;
            end

            if (took_request || o_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("sorted_multiset_count_nearest regression: fail");
                $finish;
            end
        end
    end

endmodule
